// File: rtl/lifo_stack_engine_unit_assert.svh
// Assertion macros for the LIFO stack engine
`ifndef LIFO_STACK_ENGINE_UNIT_ASSERT_SVH
`define LIFO_STACK_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTH

`define LSE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lse assertion failed");

`define LSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lse assertion failed");

`else

`define LSE_ASSERT_SAME(label, ante, cons)

`define LSE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/lse_pkg.sv
// Shared types and constants for the LIFO stack engine
package lse_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_DUMP = 3'd1,
        OP_PEEK = 3'd2,
        OP_POP  = 3'd3,
        OP_SWAP = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_PEEK_EMPTY = 3'd1,
        ST_POP_EMPTY  = 3'd2,
        ST_SWAP_SHORT = 3'd3,
        ST_PUSH_FULL  = 3'd4
    } stat_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  rd_top;
        logic  rd_next;
        logic  swap_wr_top;
        logic  swap_wr_next;
        logic  out_load;
        logic  out_data;
        logic  out_last;
        stat_t out_status;
    } ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic short_stack;
        logic ptr_zero;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/lifo_stack_engine_unit.sv
// Push, pop and failed commands pass through the report state and then the result register.
// Peek passes through the peek state; swap does two memory writes, then reports.
// A new command is taken only once the sequencer is back in its idle state, which it reaches
// when the last result of the previous command has been loaded into the result register.
// Reset clears the entry count, dump pointer and result valid flag; entries and result data are not reset.
module lifo_stack_engine_unit #(
    parameter int STACK_DEPTH = lse_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [lse_pkg::OP_W-1:0]          command,
    input  logic signed [lse_pkg::DATA_W-1:0] push_value,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [lse_pkg::DATA_W-1:0] data,
    output logic                              data_valid,
    output logic [lse_pkg::STAT_W-1:0]        status,
    output logic                              last
);

    lse_pkg::ctl_t ctl;
    lse_pkg::sts_t sts;

    lse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .sts       (sts),
        .ctl       (ctl)
    );

    lse_dpath #(
        .DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (push_value),
        .ctl        (ctl),
        .sts        (sts),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .data       (data),
        .data_valid (data_valid),
        .status     (status),
        .last       (last)
    );

endmodule

// File: rtl/lse_ctrl.sv
// Command sequencer for the LIFO stack engine
module lse_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [lse_pkg::OP_W-1:0] command,
    input  lse_pkg::sts_t           sts,
    output lse_pkg::ctl_t           ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPORT,
        S_PEEK,
        S_SWAP_TOP,
        S_SWAP_NEXT,
        S_DUMP
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    lse_pkg::stat_t stat_reg;
    lse_pkg::stat_t stat_next;

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl            = '0;
        ctl.out_status = lse_pkg::ST_OK;
        state_next     = state_reg;
        stat_next      = stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (command)
                        lse_pkg::OP_PUSH:
                        begin
                            state_next = S_REPORT;
                            if (sts.full)
                            begin
                                stat_next = lse_pkg::ST_PUSH_FULL;
                            end
                            else
                            begin
                                stat_next = lse_pkg::ST_OK;
                                ctl.push  = 1'b1;
                            end
                        end
                        lse_pkg::OP_POP:
                        begin
                            state_next = S_REPORT;
                            if (sts.empty)
                            begin
                                stat_next = lse_pkg::ST_POP_EMPTY;
                            end
                            else
                            begin
                                stat_next = lse_pkg::ST_OK;
                                ctl.pop   = 1'b1;
                            end
                        end
                        lse_pkg::OP_PEEK:
                        begin
                            if (sts.empty)
                            begin
                                stat_next  = lse_pkg::ST_PEEK_EMPTY;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                ctl.rd_top = 1'b1;
                                state_next = S_PEEK;
                            end
                        end
                        lse_pkg::OP_SWAP:
                        begin
                            if (sts.short_stack)
                            begin
                                stat_next  = lse_pkg::ST_SWAP_SHORT;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                stat_next  = lse_pkg::ST_OK;
                                ctl.rd_top = 1'b1;
                                state_next = S_SWAP_TOP;
                            end
                        end
                        lse_pkg::OP_DUMP:
                        begin
                            stat_next = lse_pkg::ST_OK;
                            if (sts.empty)
                            begin
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                ctl.rd_top = 1'b1;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REPORT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_last   = 1'b1;
                    ctl.out_status = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            S_PEEK:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_data = 1'b1;
                    ctl.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SWAP_TOP:
            begin
                ctl.swap_wr_top = 1'b1;
                state_next      = S_SWAP_NEXT;
            end
            S_SWAP_NEXT:
            begin
                ctl.swap_wr_next = 1'b1;
                state_next       = S_REPORT;
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_data = 1'b1;
                    ctl.out_last = sts.ptr_zero;
                    if (sts.ptr_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= lse_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

endmodule

// File: rtl/lse_dpath.sv
// Entry memory, fill count, dump pointer and result register
`include "lifo_stack_engine_unit_assert.svh"

module lse_dpath #(
    parameter int DEPTH = lse_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [lse_pkg::DATA_W-1:0] push_value,
    input  lse_pkg::ctl_t                    ctl,
    output lse_pkg::sts_t                    sts,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic signed [lse_pkg::DATA_W-1:0] data,
    output logic                             data_valid,
    output logic [lse_pkg::STAT_W-1:0]       status,
    output logic                             last
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [lse_pkg::DATA_W-1:0] entry_reg [DEPTH];
    logic [lse_pkg::DATA_W-1:0] rd_a_reg;
    logic [lse_pkg::DATA_W-1:0] rd_b_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [AW-1:0]              ptr_reg;
    logic [AW-1:0]              ptr_next;

    logic                       res_valid_reg;
    logic signed [lse_pkg::DATA_W-1:0] data_reg;
    logic                       data_valid_reg;
    lse_pkg::stat_t             status_reg;
    logic                       last_reg;

    logic [AW-1:0]              top_addr;
    logic [AW-1:0]              below_addr;
    logic [AW-1:0]              rd_a_addr;
    logic                       rd_a_en;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [lse_pkg::DATA_W-1:0] wr_data;
    logic                       out_free;

    assign top_addr   = AW'(cnt_reg - CNT_W'(1));
    assign below_addr = AW'(cnt_reg - CNT_W'(2));
    assign rd_a_addr  = ctl.rd_top ? top_addr : ptr_reg - AW'(1);
    assign rd_a_en    = ctl.rd_top | ctl.rd_next;
    assign out_free   = !res_valid_reg || !res_stall;

    always_comb
    begin
        wr_en   = ctl.push | ctl.swap_wr_top | ctl.swap_wr_next;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = push_value;
        if (ctl.swap_wr_top)
        begin
            wr_addr = top_addr;
            wr_data = rd_b_reg;
        end
        else if (ctl.swap_wr_next)
        begin
            wr_addr = below_addr;
            wr_data = rd_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= entry_reg[rd_a_addr];
        end
        if (ctl.rd_top)
        begin
            rd_b_reg <= entry_reg[below_addr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        ptr_next = ptr_reg;
        if (ctl.rd_top)
        begin
            ptr_next = top_addr;
        end
        else if (ctl.rd_next)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
            if (ctl.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            data_reg       <= ctl.out_data ? rd_a_reg : '0;
            data_valid_reg <= ctl.out_data;
            status_reg     <= ctl.out_status;
            last_reg       <= ctl.out_last;
        end
    end

    assign sts.empty       = (cnt_reg == '0);
    assign sts.full        = (cnt_reg == CNT_W'(DEPTH));
    assign sts.short_stack = (cnt_reg < CNT_W'(2));
    assign sts.ptr_zero    = (ptr_reg == '0);
    assign sts.out_free    = out_free;

    assign res_valid  = res_valid_reg;
    assign data       = data_reg;
    assign data_valid = data_valid_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    `LSE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `LSE_ASSERT_SAME(a_push_room, ctl.push, !sts.full)
    `LSE_ASSERT_SAME(a_pop_nonempty, ctl.pop, !sts.empty)
    `LSE_ASSERT_SAME(a_dump_ptr, ctl.rd_next, !sts.ptr_zero)
    `LSE_ASSERT_NEXT(a_load_shows, ctl.out_load, res_valid)

endmodule
